// ===== rtl/mea_pkg.sv =====
package mea_pkg;

	localparam int unsigned VTX_W = 12;
	localparam int unsigned PART_W = 16;
	localparam int unsigned STATUS_W = 2;

	typedef enum logic [STATUS_W-1:0] {
		ST_PENDING = 2'd0,
		ST_MATCHED = 2'd1,
		ST_FULL    = 2'd2
	} edge_status_t;

	typedef enum logic [1:0] {
		FSM_CLEAR,
		FSM_IDLE,
		FSM_UPDATE
	} fsm_state_t;

	typedef struct packed {
		logic hit;
		logic stored;
	} bucket_flags_t;

endpackage

// ===== rtl/mea_ram.sv =====
module mea_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

// ===== rtl/mea_bucket_logic.sv =====
module mea_bucket_logic import mea_pkg::*; #(
	parameter int unsigned BUCKET_DEPTH = 4,
	parameter int unsigned POLY_ID_BITS = 16,
	parameter int unsigned FILL_W = $clog2(BUCKET_DEPTH + 1),
	parameter int unsigned ENTRY_W = VTX_W + POLY_ID_BITS
) (
	input  logic [BUCKET_DEPTH*ENTRY_W-1:0] row,
	input  logic [FILL_W-1:0]               fill,
	input  logic [VTX_W-1:0]                high_vtx,
	input  logic [POLY_ID_BITS-1:0]         poly,
	output logic [BUCKET_DEPTH*ENTRY_W-1:0] new_row,
	output logic [FILL_W-1:0]               new_fill,
	output logic [POLY_ID_BITS-1:0]         partner,
	output bucket_flags_t                   flags
);

	localparam int unsigned IDX_W = $clog2(BUCKET_DEPTH);

	logic [FILL_W-1:0]  fill_c;
	logic [FILL_W-1:0]  last;
	logic [IDX_W-1:0]   hit_idx;
	logic               hit;
	logic [ENTRY_W-1:0] last_entry;
	logic [ENTRY_W-1:0] hit_entry;

	always_comb begin
		fill_c = (fill > FILL_W'(BUCKET_DEPTH)) ? FILL_W'(BUCKET_DEPTH) : fill;
		last = fill_c - FILL_W'(1);
		hit = 1'b0;
		hit_idx = '0;
		last_entry = '0;
		hit_entry = '0;
		// scan from the top so the first match in bucket order wins
		for (int e = BUCKET_DEPTH - 1; e >= 0; e--) begin
			if ((FILL_W'(e) < fill_c) && (row[e*ENTRY_W +: VTX_W] == high_vtx)) begin
				hit = 1'b1;
				hit_idx = IDX_W'(e);
				hit_entry = row[e*ENTRY_W +: ENTRY_W];
			end
		end
		for (int e = 0; e < BUCKET_DEPTH; e++) begin
			if (FILL_W'(e) == last) begin
				last_entry = row[e*ENTRY_W +: ENTRY_W];
			end
		end
	end

	always_comb begin
		new_row = row;
		new_fill = fill_c;
		flags.hit = hit;
		flags.stored = 1'b0;
		partner = hit_entry[ENTRY_W-1:VTX_W];
		if (hit) begin
			new_fill = last;
			for (int e = 0; e < BUCKET_DEPTH; e++) begin
				if (IDX_W'(e) == hit_idx) begin
					new_row[e*ENTRY_W +: ENTRY_W] = last_entry;
				end
			end
		end else if (fill_c < FILL_W'(BUCKET_DEPTH)) begin
			flags.stored = 1'b1;
			new_fill = fill_c + FILL_W'(1);
			for (int e = 0; e < BUCKET_DEPTH; e++) begin
				if (FILL_W'(e) == fill_c) begin
					new_row[e*ENTRY_W +: ENTRY_W] = {poly, high_vtx};
				end
			end
		end
	end

endmodule

// ===== rtl/mesh_edge_adjacency_matcher.sv =====
// channel | direction | transaction fields
// in      | sink      | vertex_a, vertex_b, polygon_id
// out     | source    | status, partner_polygon, low_vertex, high_vertex
//
// bucket fill and bucket row are read in the accept cycle, searched in the update
// state and written back when the output register is free; no new edge is taken
// until then. after reset a clearing pass zeroes the fill ram one address at a
// time, during which no edge is taken. a stalled result waits in the output
// register while the next edge is accepted; the update waits until it is free.
module mesh_edge_adjacency_matcher import mea_pkg::*; #(
	parameter int unsigned VERTEX_SLOTS = 4096,
	parameter int unsigned BUCKET_DEPTH = 4,
	parameter int unsigned POLY_ID_BITS = 16
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [VTX_W-1:0]    vertex_a,
	input  logic [VTX_W-1:0]    vertex_b,
	input  logic [15:0]         polygon_id,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [STATUS_W-1:0] status,
	output logic [PART_W-1:0]   partner_polygon,
	output logic [VTX_W-1:0]    low_vertex,
	output logic [VTX_W-1:0]    high_vertex
);

	localparam int unsigned ADDR_W = $clog2(VERTEX_SLOTS);
	localparam int unsigned FILL_W = $clog2(BUCKET_DEPTH + 1);
	localparam int unsigned ENTRY_W = VTX_W + POLY_ID_BITS;
	localparam int unsigned ROW_W = BUCKET_DEPTH * ENTRY_W;

	fsm_state_t state_q, state_d;

	logic [ADDR_W-1:0]       clr_q;
	logic [VTX_W-1:0]        lo_q, hi_q;
	logic [POLY_ID_BITS-1:0] poly_q;
	logic                    in_range_q;
	logic                    out_valid_q;
	edge_status_t            status_q;
	logic [PART_W-1:0]       partner_q;
	logic [VTX_W-1:0]        lo_out_q, hi_out_q;

	logic [VTX_W-1:0]        lo_c, hi_c;
	logic [31:0]             lo_ext;
	logic [31:0]             lo_q_ext;
	logic [31:0]             poly_ext;
	logic                    accept;
	logic                    out_load;
	logic                    fill_we, row_we;
	logic [ADDR_W-1:0]       fill_waddr;
	logic [FILL_W-1:0]       fill_wdata, fill_rdata, new_fill;
	logic [ROW_W-1:0]        row_rdata, new_row;
	logic [POLY_ID_BITS-1:0] partner_raw;
	logic [31:0]             partner_ext;
	bucket_flags_t           flags;
	edge_status_t            status_c;

	assign lo_c = (vertex_a <= vertex_b) ? vertex_a : vertex_b;
	assign hi_c = (vertex_a <= vertex_b) ? vertex_b : vertex_a;
	assign lo_ext = 32'(lo_c);
	assign lo_q_ext = 32'(lo_q);
	assign poly_ext = 32'(polygon_id);
	assign partner_ext = 32'(partner_raw);

	assign in_ready = (state_q == FSM_IDLE);
	assign accept = in_valid && in_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FSM_CLEAR;
			clr_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == FSM_CLEAR) begin
				clr_q <= clr_q + ADDR_W'(1);
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			lo_q <= lo_c;
			hi_q <= hi_c;
			poly_q <= poly_ext[POLY_ID_BITS-1:0];
			in_range_q <= (lo_ext < 32'(VERTEX_SLOTS));
		end
		if (out_load) begin
			status_q <= status_c;
			partner_q <= (status_c == ST_MATCHED) ? partner_ext[PART_W-1:0] : '0;
			lo_out_q <= lo_q;
			hi_out_q <= hi_q;
		end
	end

	always_comb begin
		if (!in_range_q) begin
			status_c = ST_FULL;
		end else if (flags.hit) begin
			status_c = ST_MATCHED;
		end else if (flags.stored) begin
			status_c = ST_PENDING;
		end else begin
			status_c = ST_FULL;
		end
	end

	always_comb begin
		state_d = state_q;
		out_load = 1'b0;
		fill_we = 1'b0;
		row_we = 1'b0;
		fill_waddr = lo_q_ext[ADDR_W-1:0];
		fill_wdata = new_fill;
		unique case (state_q)
			FSM_CLEAR: begin
				fill_we = 1'b1;
				fill_waddr = clr_q;
				fill_wdata = '0;
				if (clr_q == ADDR_W'(VERTEX_SLOTS - 1)) begin
					state_d = FSM_IDLE;
				end
			end
			FSM_IDLE: begin
				if (accept) begin
					state_d = FSM_UPDATE;
				end
			end
			FSM_UPDATE: begin
				if (!out_valid_q || out_ready) begin
					out_load = 1'b1;
					fill_we = in_range_q && (flags.hit || flags.stored);
					row_we = fill_we;
					state_d = FSM_IDLE;
				end
			end
			default: begin
				state_d = FSM_IDLE;
			end
		endcase
	end

	mea_ram #(
		.WIDTH(FILL_W),
		.DEPTH(VERTEX_SLOTS)
	) u_fill_ram (
		.clk  (clk),
		.we   (fill_we),
		.waddr(fill_waddr),
		.wdata(fill_wdata),
		.re   (accept),
		.raddr(lo_ext[ADDR_W-1:0]),
		.rdata(fill_rdata)
	);

	mea_ram #(
		.WIDTH(ROW_W),
		.DEPTH(VERTEX_SLOTS)
	) u_row_ram (
		.clk  (clk),
		.we   (row_we),
		.waddr(lo_q_ext[ADDR_W-1:0]),
		.wdata(new_row),
		.re   (accept),
		.raddr(lo_ext[ADDR_W-1:0]),
		.rdata(row_rdata)
	);

	mea_bucket_logic #(
		.BUCKET_DEPTH(BUCKET_DEPTH),
		.POLY_ID_BITS(POLY_ID_BITS)
	) u_bucket (
		.row     (row_rdata),
		.fill    (fill_rdata),
		.high_vtx(hi_q),
		.poly    (poly_q),
		.new_row (new_row),
		.new_fill(new_fill),
		.partner (partner_raw),
		.flags   (flags)
	);

	assign out_valid = out_valid_q;
	assign status = status_q;
	assign partner_polygon = partner_q;
	assign low_vertex = lo_out_q;
	assign high_vertex = hi_out_q;

endmodule
